/* design/mrte_pkg.sv */
// Shared types and codes for the R-type execute unit.
package mrte_pkg;

	typedef enum logic [4:0] {
		MODE_SLL  = 5'd0,
		MODE_SRL  = 5'd1,
		MODE_SRA  = 5'd2,
		MODE_SLLV = 5'd3,
		MODE_SRLV = 5'd4,
		MODE_SRAV = 5'd5,
		MODE_MFHI = 5'd6,
		MODE_MTHI = 5'd7,
		MODE_MFLO = 5'd8,
		MODE_MTLO = 5'd9,
		MODE_MULT = 5'd10,
		MODE_MULTU = 5'd11,
		MODE_DIV  = 5'd12,
		MODE_DIVU = 5'd13,
		MODE_ADD  = 5'd14,
		MODE_ADDU = 5'd15,
		MODE_SUB  = 5'd16,
		MODE_SUBU = 5'd17,
		MODE_AND  = 5'd18,
		MODE_OR   = 5'd19,
		MODE_XOR  = 5'd20,
		MODE_SLT  = 5'd21,
		MODE_SLTU = 5'd22
	} mode_t;

	localparam logic [4:0] StepLast = 5'd31;

	typedef struct packed {
		logic [4:0]  mode;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
		logic [4:0]  shift_amount;
		logic [4:0]  dest_index;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        write_enable;
		logic [4:0]  write_index;
		logic        overflow_trap;
		logic        divide_by_zero;
	} rsp_t;

	// HI/LO writes requested by an ALU operation (MTHI/MTLO)
	typedef struct packed {
		logic        hi_we;
		logic        lo_we;
		logic [31:0] wdata;
	} hilo_wr_t;

	typedef struct packed {
		logic is_div;
		logic is_signed;
	} md_cmd_t;

	typedef struct packed {
		logic        done;
		logic        div_zero;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_stat_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIX
	} md_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_HOLD
	} top_state_t;

endpackage

/* design/mips_r_type_execute_unit.sv */
// MIPS32 R-type execute unit with HI/LO and bit-serial multiply/divide.
// ALU operations are combinational and registered at the output; mult/multu/div/divu
// run a start step, 32 shift-add / restoring-divide steps and a sign-fix step.
// A divide by zero skips the steps. One item in flight; a held result stalls input.
// Throughput: one ALU item per cycle unless the output stalls; mul/div stalls input.
// Reset clears HI, LO, the control state and the output valid.
module mips_r_type_execute_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  mrte_pkg::req_t  req_item,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mrte_pkg::rsp_t  rsp_item
);

	mrte_pkg::top_state_t state_q, state_d;

	logic [31:0]         hi_q;
	logic [31:0]         lo_q;
	logic [4:0]          idx_q;
	logic                rsp_valid_q;
	mrte_pkg::rsp_t      rsp_q;
	mrte_pkg::rsp_t      pend_q;

	mrte_pkg::rsp_t      alu_rsp;
	mrte_pkg::hilo_wr_t  hilo_wr;
	mrte_pkg::md_cmd_t   md_cmd;
	mrte_pkg::md_stat_t  md_stat;
	mrte_pkg::rsp_t      fin_item;

	logic acc;
	logic is_md;
	logic fin;
	logic out_free;

	mrte_alu u_alu (
		.req     (req_item),
		.hi      (hi_q),
		.lo      (lo_q),
		.rsp     (alu_rsp),
		.hilo_wr (hilo_wr)
	);

	mrte_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc && is_md),
		.cmd    (md_cmd),
		.a      (req_item.rs_value),
		.b      (req_item.rt_value),
		.stat   (md_stat)
	);

	assign is_md = (req_item.mode == mrte_pkg::MODE_MULT) ||
	               (req_item.mode == mrte_pkg::MODE_MULTU) ||
	               (req_item.mode == mrte_pkg::MODE_DIV) ||
	               (req_item.mode == mrte_pkg::MODE_DIVU);
	assign md_cmd.is_div    = (req_item.mode == mrte_pkg::MODE_DIV) ||
	                          (req_item.mode == mrte_pkg::MODE_DIVU);
	assign md_cmd.is_signed = (req_item.mode == mrte_pkg::MODE_MULT) ||
	                          (req_item.mode == mrte_pkg::MODE_DIV);

	assign acc      = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fin      = (acc && !is_md) || md_stat.done;

	always_comb begin
		fin_item = alu_rsp;
		if (md_stat.done) begin
			fin_item                = '0;
			fin_item.write_index    = idx_q;
			fin_item.divide_by_zero = md_stat.div_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			mrte_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (acc && is_md) begin
					state_d = mrte_pkg::ST_BUSY;
				end else if (acc && !out_free) begin
					state_d = mrte_pkg::ST_HOLD;
				end
			end
			mrte_pkg::ST_BUSY: begin
				if (md_stat.done) begin
					state_d = out_free ? mrte_pkg::ST_IDLE : mrte_pkg::ST_HOLD;
				end
			end
			mrte_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = mrte_pkg::ST_IDLE;
				end
			end
			default: state_d = mrte_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q        <= '0;
			lo_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc && hilo_wr.hi_we) begin
				hi_q <= hilo_wr.wdata;
			end
			if (acc && hilo_wr.lo_we) begin
				lo_q <= hilo_wr.wdata;
			end
			if (md_stat.done && !md_stat.div_zero) begin
				hi_q <= md_stat.hi;
				lo_q <= md_stat.lo;
			end
			if (out_free) begin
				rsp_valid_q <= fin || (state_q == mrte_pkg::ST_HOLD);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_q <= req_item.dest_index;
		end
		// park the result while the output is stalled
		if (fin && !out_free) begin
			pend_q <= fin_item;
		end
		if (out_free) begin
			rsp_q <= (state_q == mrte_pkg::ST_HOLD) ? pend_q : fin_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.done |-> (state_q == mrte_pkg::ST_BUSY))
		else $error("multiply/divide finished outside busy state");

	a_hold_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrte_pkg::ST_HOLD) |-> rsp_valid_q)
		else $error("result parked while output register empty");

	a_trap_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_item.overflow_trap && rsp_item.write_enable))
		else $error("overflow trap with register write");

	a_busy_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrte_pkg::ST_BUSY && !md_stat.done && !$past(state_q == mrte_pkg::ST_IDLE))
		|-> (!rsp_valid || $stable(rsp_item)))
		else $error("output changed while multiply/divide running");

endmodule

/* design/mrte_alu.sv */
// Combinational ALU operations: shifts, add/sub, logic, compares and HI/LO moves.
module mrte_alu (
	input  mrte_pkg::req_t     req,
	input  logic [31:0]        hi,
	input  logic [31:0]        lo,
	output mrte_pkg::rsp_t     rsp,
	output mrte_pkg::hilo_wr_t hilo_wr
);

	logic [31:0] a;
	logic [31:0] b;
	logic [4:0]  sh_imm;
	logic [4:0]  sh_var;
	logic [31:0] sum;
	logic [31:0] dif;
	logic        add_ovf;
	logic        sub_ovf;

	assign a       = req.rs_value;
	assign b       = req.rt_value;
	assign sh_imm  = req.shift_amount;
	assign sh_var  = a[4:0];
	assign sum     = a + b;
	assign dif     = a - b;
	assign add_ovf = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
	assign sub_ovf = (a[31] ^ b[31]) & (a[31] ^ dif[31]);

	always_comb begin
		rsp                = '0;
		rsp.write_index    = req.dest_index;
		hilo_wr            = '0;
		hilo_wr.wdata      = a;
		case (mrte_pkg::mode_t'(req.mode))
			mrte_pkg::MODE_SLL: begin
				rsp.result_value = b << sh_imm;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SRL: begin
				rsp.result_value = b >> sh_imm;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SRA: begin
				rsp.result_value = $unsigned($signed(b) >>> sh_imm);
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SLLV: begin
				rsp.result_value = b << sh_var;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SRLV: begin
				rsp.result_value = b >> sh_var;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SRAV: begin
				rsp.result_value = $unsigned($signed(b) >>> sh_var);
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_MFHI: begin
				rsp.result_value = hi;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_MTHI: hilo_wr.hi_we = 1'b1;
			mrte_pkg::MODE_MFLO: begin
				rsp.result_value = lo;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_MTLO: hilo_wr.lo_we = 1'b1;
			mrte_pkg::MODE_ADD: begin
				// trap: suppress the write
				if (add_ovf) begin
					rsp.overflow_trap = 1'b1;
				end else begin
					rsp.result_value = sum;
					rsp.write_enable = 1'b1;
				end
			end
			mrte_pkg::MODE_ADDU: begin
				rsp.result_value = sum;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SUB: begin
				if (sub_ovf) begin
					rsp.overflow_trap = 1'b1;
				end else begin
					rsp.result_value = dif;
					rsp.write_enable = 1'b1;
				end
			end
			mrte_pkg::MODE_SUBU: begin
				rsp.result_value = dif;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_AND: begin
				rsp.result_value = a & b;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_OR: begin
				rsp.result_value = a | b;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_XOR: begin
				rsp.result_value = a ^ b;
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SLT: begin
				rsp.result_value = {31'd0, ($signed(a) < $signed(b))};
				rsp.write_enable = 1'b1;
			end
			mrte_pkg::MODE_SLTU: begin
				rsp.result_value = {31'd0, (a < b)};
				rsp.write_enable = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* design/mrte_muldiv.sv */
// Bit-serial multiply (shift-add) and divide (restoring), one bit per cycle.
module mrte_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mrte_pkg::md_cmd_t   cmd,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	output mrte_pkg::md_stat_t  stat
);

	mrte_pkg::md_state_t state_q, state_d;

	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] opnd_q;
	logic [4:0]  cnt_q;
	logic        div_q;
	logic        neg_q;
	logic        rneg_q;
	logic        dz_q;

	logic [31:0] mag_a;
	logic [31:0] mag_b;
	logic [32:0] add_sum;
	logic [32:0] trial;
	logic [63:0] prod;
	logic [63:0] prod_fix;

	assign mag_a    = (cmd.is_signed && a[31]) ? (32'd0 - a) : a;
	assign mag_b    = (cmd.is_signed && b[31]) ? (32'd0 - b) : b;
	assign add_sum  = {1'b0, hi_q} + {1'b0, opnd_q};
	assign trial    = {hi_q, lo_q[31]} - {1'b0, opnd_q};
	assign prod     = {hi_q, lo_q};
	assign prod_fix = neg_q ? (64'd0 - prod) : prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrte_pkg::MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		stat          = '0;
		stat.div_zero = dz_q;
		case (state_q)
			mrte_pkg::MD_IDLE: begin
				if (start) begin
					state_d = (cmd.is_div && (b == 32'd0)) ? mrte_pkg::MD_FIX
					                                       : mrte_pkg::MD_RUN;
				end
			end
			mrte_pkg::MD_RUN: begin
				if (cnt_q == 5'd0) begin
					state_d = mrte_pkg::MD_FIX;
				end
			end
			mrte_pkg::MD_FIX: begin
				stat.done = 1'b1;
				if (div_q) begin
					stat.lo = neg_q ? (32'd0 - lo_q) : lo_q;
					stat.hi = rneg_q ? (32'd0 - hi_q) : hi_q;
				end else begin
					stat.hi = prod_fix[63:32];
					stat.lo = prod_fix[31:0];
				end
				state_d = mrte_pkg::MD_IDLE;
			end
			default: state_d = mrte_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == mrte_pkg::MD_IDLE && start) begin
			div_q  <= cmd.is_div;
			neg_q  <= cmd.is_signed && (a[31] ^ b[31]);
			rneg_q <= cmd.is_signed && a[31];
			dz_q   <= cmd.is_div && (b == 32'd0);
			cnt_q  <= mrte_pkg::StepLast;
			hi_q   <= '0;
			lo_q   <= cmd.is_div ? mag_a : mag_b;
			opnd_q <= cmd.is_div ? mag_b : mag_a;
		end else if (state_q == mrte_pkg::MD_RUN) begin
			cnt_q <= cnt_q - 5'd1;
			if (div_q) begin
				// keep the trial difference when it does not go negative
				hi_q <= trial[32] ? {hi_q[30:0], lo_q[31]} : trial[31:0];
				lo_q <= {lo_q[30:0], ~trial[32]};
			end else if (lo_q[0]) begin
				hi_q <= add_sum[32:1];
				lo_q <= {add_sum[0], lo_q[31:1]};
			end else begin
				hi_q <= {1'b0, hi_q[31:1]};
				lo_q <= {hi_q[0], lo_q[31:1]};
			end
		end
	end

endmodule
